// ----- rtl/dtoa_pkg.sv -----
// shared types, constants and lookup functions of the date-time offset adder
package dtoa_pkg;

  // working width of signed date-time fields before normalization
  localparam int DT_W = 34;
  // remainder width, wide enough for the largest divisor
  localparam int REM_W = 11;
  // divider operand magnitude width; every dividend stays below 2**32 in magnitude
  localparam int MAG_W = 32;

  localparam int MIN_SEC    = 60;
  localparam int DAY_HOURS  = 24;
  localparam int MONTHS     = 12;
  localparam int CYCLE_DAYS = 1461;
  localparam logic [15:0] YEAR_MAX = 16'hFFFF;

  // reciprocal shifts: operand width plus the bit length of the divisor
  localparam int SHIFT_SIXTY  = MAG_W + $clog2(MIN_SEC);
  localparam int SHIFT_HOURS  = MAG_W + $clog2(DAY_HOURS);
  localparam int SHIFT_MONTHS = MAG_W + $clog2(MONTHS);
  localparam int SHIFT_CYCLE  = MAG_W + $clog2(CYCLE_DAYS);

  typedef logic [MAG_W:0] recip_t;

  // rounded-up reciprocals, exact floor quotients for any operand below 2**MAG_W
  localparam recip_t RECIP_SIXTY  =
    recip_t'(((64'd1 << SHIFT_SIXTY) + 64'(MIN_SEC - 1)) / 64'(MIN_SEC));
  localparam recip_t RECIP_HOURS  =
    recip_t'(((64'd1 << SHIFT_HOURS) + 64'(DAY_HOURS - 1)) / 64'(DAY_HOURS));
  localparam recip_t RECIP_MONTHS =
    recip_t'(((64'd1 << SHIFT_MONTHS) + 64'(MONTHS - 1)) / 64'(MONTHS));
  localparam recip_t RECIP_CYCLE  =
    recip_t'(((64'd1 << SHIFT_CYCLE) + 64'(CYCLE_DAYS - 1)) / 64'(CYCLE_DAYS));

  // unit codes of an input beat
  localparam logic [2:0] UNIT_YEAR   = 3'd0;
  localparam logic [2:0] UNIT_MONTH  = 3'd1;
  localparam logic [2:0] UNIT_DAY    = 3'd2;
  localparam logic [2:0] UNIT_HOUR   = 3'd3;
  localparam logic [2:0] UNIT_MINUTE = 3'd4;
  localparam logic [2:0] UNIT_SECOND = 3'd5;

  // divisor select codes of the shared divider
  localparam logic [1:0] DIV_SIXTY  = 2'd0;
  localparam logic [1:0] DIV_HOURS  = 2'd1;
  localparam logic [1:0] DIV_MONTHS = 2'd2;
  localparam logic [1:0] DIV_CYCLE  = 2'd3;

  typedef logic signed [DT_W-1:0] dt_val_t;

  typedef struct packed {
    logic [13:0] start_year;
    logic [3:0]  start_month;
    logic [4:0]  start_day;
    logic [4:0]  start_hour;
    logic [5:0]  start_minute;
    logic [5:0]  start_second;
    logic [2:0]  unit;
    logic        subtract;
    logic [30:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_year;
    logic [3:0]  result_month;
    logic [4:0]  result_day;
    logic [4:0]  result_hour;
    logic [5:0]  result_minute;
    logic [5:0]  result_second;
    logic        year_out_of_range;
  } out_item_t;

  // request to the shared floor divider
  typedef struct packed {
    logic       start;
    logic [1:0] sel;
    dt_val_t    dividend;
  } div_req_t;

  // response of the shared floor divider
  typedef struct packed {
    logic             done;
    dt_val_t          quot;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  // divisor constant for a select code
  function automatic logic [REM_W-1:0] div_value(input logic [1:0] sel);
    logic [REM_W-1:0] v;
    unique case (sel)
      DIV_SIXTY:  v = REM_W'(MIN_SEC);
      DIV_HOURS:  v = REM_W'(DAY_HOURS);
      DIV_MONTHS: v = REM_W'(MONTHS);
      DIV_CYCLE:  v = REM_W'(CYCLE_DAYS);
      default:    v = REM_W'(CYCLE_DAYS);
    endcase
    return v;
  endfunction

  // reciprocal constant for a select code
  function automatic recip_t div_recip(input logic [1:0] sel);
    recip_t v;
    unique case (sel)
      DIV_SIXTY:  v = RECIP_SIXTY;
      DIV_HOURS:  v = RECIP_HOURS;
      DIV_MONTHS: v = RECIP_MONTHS;
      DIV_CYCLE:  v = RECIP_CYCLE;
      default:    v = RECIP_CYCLE;
    endcase
    return v;
  endfunction

  // days in a month, month index counted from zero
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mo0);
    logic [4:0] v;
    unique case (mo0)
      4'd1:    v = leap ? 5'd29 : 5'd28;
      4'd3:    v = 5'd30;
      4'd5:    v = 5'd30;
      4'd8:    v = 5'd30;
      4'd10:   v = 5'd30;
      default: v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/dtoa_if.sv -----
// valid/ready channel interfaces for input and result beats
interface dtoa_in_if;
  logic               valid;
  logic               ready;
  dtoa_pkg::in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface dtoa_out_if;
  logic                valid;
  logic                ready;
  dtoa_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/dtoa_div.sv -----
// shared floor divider by a selectable constant, by reciprocal multiplication
module dtoa_div (
  input  logic               clk,
  input  logic               rst,
  input  dtoa_pkg::div_req_t req,
  output dtoa_pkg::div_rsp_t rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_PRD  = 2'd2;
  localparam logic [1:0] ST_FIX  = 2'd3;

  logic [1:0]                     state;
  logic                           neg;
  logic [dtoa_pkg::MAG_W-1:0]     mag;
  logic [1:0]                     sel;
  logic [2*dtoa_pkg::MAG_W:0]     acc;
  logic [dtoa_pkg::MAG_W-1:0]     q;
  logic [dtoa_pkg::MAG_W-1:0]     qc;
  logic [dtoa_pkg::REM_W-1:0]     divisor;
  logic [dtoa_pkg::REM_W-1:0]     div_now;
  dtoa_pkg::recip_t               recip;
  logic                           skip;
  logic [dtoa_pkg::MAG_W-1:0]     q_now;
  logic [dtoa_pkg::MAG_W-1:0]     mul_a;
  logic [dtoa_pkg::MAG_W-1:0]     mul_b;
  logic [2*dtoa_pkg::MAG_W-1:0]   mul_p;
  logic [dtoa_pkg::MAG_W-1:0]     r_full;
  logic [dtoa_pkg::REM_W-1:0]     r;

  assign divisor = dtoa_pkg::div_value(sel);
  assign div_now = dtoa_pkg::div_value(req.sel);
  assign recip   = dtoa_pkg::div_recip(sel);

  // operand already in range needs no multiply
  assign skip = !req.dividend[dtoa_pkg::DT_W-1] &&
                ($unsigned(req.dividend) < dtoa_pkg::DT_W'(div_now));

  // quotient taken from the reciprocal product
  always_comb begin
    unique case (sel)
      dtoa_pkg::DIV_SIXTY:  q_now = dtoa_pkg::MAG_W'(acc >> dtoa_pkg::SHIFT_SIXTY);
      dtoa_pkg::DIV_HOURS:  q_now = dtoa_pkg::MAG_W'(acc >> dtoa_pkg::SHIFT_HOURS);
      dtoa_pkg::DIV_MONTHS: q_now = dtoa_pkg::MAG_W'(acc >> dtoa_pkg::SHIFT_MONTHS);
      default:              q_now = dtoa_pkg::MAG_W'(acc >> dtoa_pkg::SHIFT_CYCLE);
    endcase
  end

  // one multiplier: operand times reciprocal, then quotient times divisor
  assign mul_a = (state == ST_MUL) ? mag : q_now;
  assign mul_b = (state == ST_MUL) ? recip[dtoa_pkg::MAG_W-1:0]
                                   : dtoa_pkg::MAG_W'(divisor);
  assign mul_p = mul_a * mul_b;

  // remainder of the magnitude, always below the divisor
  assign r_full = mag - qc;
  assign r      = r_full[dtoa_pkg::REM_W-1:0];

  // sequencer of the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            neg <= req.dividend[dtoa_pkg::DT_W-1];
            mag <= req.dividend[dtoa_pkg::DT_W-1] ?
                   dtoa_pkg::MAG_W'($unsigned(-req.dividend)) :
                   dtoa_pkg::MAG_W'($unsigned(req.dividend));
            sel <= req.sel;
            if (skip) begin
              rsp.quot <= '0;
              rsp.rem  <= req.dividend[dtoa_pkg::REM_W-1:0];
              rsp.done <= 1'b1;
            end else begin
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          // top reciprocal bit adds the operand one word up
          acc   <= {1'b0, mul_p} +
                   (recip[dtoa_pkg::MAG_W] ? {1'b0, mag, {dtoa_pkg::MAG_W{1'b0}}} : '0);
          state <= ST_PRD;
        end
        ST_PRD: begin
          q     <= q_now;
          qc    <= mul_p[dtoa_pkg::MAG_W-1:0];
          state <= ST_FIX;
        end
        ST_FIX: begin
          // round the quotient toward minus infinity for negative operands
          if (neg && (r != '0)) begin
            rsp.quot <= ~dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(q));
            rsp.rem  <= divisor - r;
          end else if (neg) begin
            rsp.quot <= -dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(q));
            rsp.rem  <= '0;
          end else begin
            rsp.quot <= dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(q));
            rsp.rem  <= r;
          end
          rsp.done <= 1'b1;
          state    <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/date_time_offset_adder_core.sv -----
// top level: add/subtract sequencer, month walk and result register
// One beat is taken while the block is idle; the selected field gets the amount added or
// subtracted, then seconds, minutes, hours, months and days are normalized in that order by
// one shared floor divider (by 60, 60, 24, 12 and 1461). A division whose operand is already
// in range skips the multiply; any other goes through issue, reciprocal multiply, quotient
// times divisor, fix-up and hand-back. Then a month walk takes the day within a four-year
// cycle apart, one month per step. A beat may also wait for the result register to free up.
// A finished result waits in the output register, so the next beat can be taken while it is
// not yet picked up. Years outside 0..65535 saturate and raise year_out_of_range.
module date_time_offset_adder_core (
  input logic        clk,
  input logic        rst,
  dtoa_in_if.sink    in_item,
  dtoa_out_if.source out_item
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;

  localparam logic [2:0] STG_SEC  = 3'd0;
  localparam logic [2:0] STG_MIN  = 3'd1;
  localparam logic [2:0] STG_HOUR = 3'd2;
  localparam logic [2:0] STG_MON  = 3'd3;
  localparam logic [2:0] STG_DAY  = 3'd4;

  logic [2:0] state;
  logic [2:0] stage;

  dtoa_pkg::dt_val_t y;
  dtoa_pkg::dt_val_t mo;
  dtoa_pkg::dt_val_t d;
  dtoa_pkg::dt_val_t h;
  dtoa_pkg::dt_val_t mi;
  dtoa_pkg::dt_val_t s;

  dtoa_pkg::dt_val_t y_init;
  dtoa_pkg::dt_val_t mo_init;
  dtoa_pkg::dt_val_t d_init;
  dtoa_pkg::dt_val_t h_init;
  dtoa_pkg::dt_val_t mi_init;
  dtoa_pkg::dt_val_t s_init;
  dtoa_pkg::dt_val_t base;
  dtoa_pkg::dt_val_t amt;
  dtoa_pkg::dt_val_t sum;
  dtoa_pkg::dt_val_t rem_ext;

  dtoa_pkg::div_req_t div_req;
  dtoa_pkg::div_rsp_t div_rsp;

  logic                       accept;
  logic                       out_free;
  logic [4:0]                 len;
  logic [dtoa_pkg::REM_W-1:0] day_left;
  logic                       y_neg;
  logic                       y_big;

  dtoa_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_item.ready = (state == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign out_free      = !out_item.valid || out_item.ready;

  // start values; month and day are kept counted from zero
  assign y_init  = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_year));
  assign mo_init = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_month))
                   - dtoa_pkg::dt_val_t'(1);
  assign d_init  = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_day))
                   - dtoa_pkg::dt_val_t'(1);
  assign h_init  = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_hour));
  assign mi_init = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_minute));
  assign s_init  = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.start_second));
  assign amt     = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(in_item.data.amount));

  // one add/subtract on the field that the unit selects
  always_comb begin
    case (in_item.data.unit)
      dtoa_pkg::UNIT_YEAR:   base = y_init;
      dtoa_pkg::UNIT_MONTH:  base = mo_init;
      dtoa_pkg::UNIT_DAY:    base = d_init;
      dtoa_pkg::UNIT_HOUR:   base = h_init;
      dtoa_pkg::UNIT_MINUTE: base = mi_init;
      dtoa_pkg::UNIT_SECOND: base = s_init;
      default:               base = '0;
    endcase
    sum = in_item.data.subtract ? (base - amt) : (base + amt);
  end

  // divider operand and divisor per normalization stage
  always_comb begin
    div_req.start = (state == ST_ISSUE);
    unique case (stage)
      STG_SEC: begin
        div_req.sel      = dtoa_pkg::DIV_SIXTY;
        div_req.dividend = s;
      end
      STG_MIN: begin
        div_req.sel      = dtoa_pkg::DIV_SIXTY;
        div_req.dividend = mi;
      end
      STG_HOUR: begin
        div_req.sel      = dtoa_pkg::DIV_HOURS;
        div_req.dividend = h;
      end
      STG_MON: begin
        div_req.sel      = dtoa_pkg::DIV_MONTHS;
        div_req.dividend = mo;
      end
      default: begin
        div_req.sel      = dtoa_pkg::DIV_CYCLE;
        div_req.dividend = d;
      end
    endcase
  end

  assign rem_ext = dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(div_rsp.rem));

  // month walk step and year range check
  assign len      = dtoa_pkg::month_len(y[1:0] == 2'b00, mo[3:0]);
  assign day_left = d[dtoa_pkg::REM_W-1:0] - dtoa_pkg::REM_W'(len);
  assign y_neg    = y[dtoa_pkg::DT_W-1];
  assign y_big    = !y_neg && (|y[dtoa_pkg::DT_W-2:16]);

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= STG_SEC;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_ISSUE;
            stage <= STG_SEC;
          end
        end
        ST_ISSUE: begin
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            if (stage == STG_DAY) begin
              state <= ST_WALK;
            end else begin
              stage <= stage + 3'd1;
              state <= ST_ISSUE;
            end
          end
        end
        ST_WALK: begin
          if (d[dtoa_pkg::REM_W-1:0] < dtoa_pkg::REM_W'(len)) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // date-time working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      y  <= (in_item.data.unit == dtoa_pkg::UNIT_YEAR)   ? sum : y_init;
      mo <= (in_item.data.unit == dtoa_pkg::UNIT_MONTH)  ? sum : mo_init;
      d  <= (in_item.data.unit == dtoa_pkg::UNIT_DAY)    ? sum : d_init;
      h  <= (in_item.data.unit == dtoa_pkg::UNIT_HOUR)   ? sum : h_init;
      mi <= (in_item.data.unit == dtoa_pkg::UNIT_MINUTE) ? sum : mi_init;
      s  <= (in_item.data.unit == dtoa_pkg::UNIT_SECOND) ? sum : s_init;
    end else if ((state == ST_WAIT) && div_rsp.done) begin
      unique case (stage)
        STG_SEC: begin
          s  <= rem_ext;
          mi <= mi + div_rsp.quot;
        end
        STG_MIN: begin
          mi <= rem_ext;
          h  <= h + div_rsp.quot;
        end
        STG_HOUR: begin
          h <= rem_ext;
          d <= d + div_rsp.quot;
        end
        STG_MON: begin
          mo <= rem_ext;
          y  <= y + div_rsp.quot;
        end
        default: begin
          d <= rem_ext;
          y <= y + (div_rsp.quot <<< 2);
        end
      endcase
    end else if ((state == ST_WALK) &&
                 !(d[dtoa_pkg::REM_W-1:0] < dtoa_pkg::REM_W'(len))) begin
      d <= dtoa_pkg::dt_val_t'(dtoa_pkg::DT_W'(day_left));
      if (mo[3:0] == 4'(dtoa_pkg::MONTHS - 1)) begin
        mo <= '0;
        y  <= y + dtoa_pkg::dt_val_t'(1);
      end else begin
        mo <= mo + dtoa_pkg::dt_val_t'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if ((state == ST_SAT) && out_free) begin
      out_item.valid <= 1'b1;
    end else if (out_item.ready) begin
      out_item.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_SAT) && out_free) begin
      out_item.data.result_year       <= y_neg ? 16'd0 : (y_big ? dtoa_pkg::YEAR_MAX : y[15:0]);
      out_item.data.year_out_of_range <= y_neg || y_big;
      out_item.data.result_month      <= mo[3:0] + 4'd1;
      out_item.data.result_day        <= d[4:0] + 5'd1;
      out_item.data.result_hour       <= h[4:0];
      out_item.data.result_minute     <= mi[5:0];
      out_item.data.result_second     <= s[5:0];
    end
  end

  // divider answers only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_WAIT))
    else $error("divider result outside wait state");

  // month walk starts from a reduced day and month
  a_walk_operands: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (!d[dtoa_pkg::DT_W-1] &&
      (d < dtoa_pkg::dt_val_t'(dtoa_pkg::CYCLE_DAYS)) &&
      !mo[dtoa_pkg::DT_W-1] && (mo < dtoa_pkg::dt_val_t'(dtoa_pkg::MONTHS))))
    else $error("month walk operands not reduced");

  // a delivered date is normalized
  a_result_date: assert property (@(posedge clk) disable iff (rst)
    out_item.valid |-> ((out_item.data.result_month >= 4'd1) &&
      (out_item.data.result_month <= 4'd12) && (out_item.data.result_day >= 5'd1) &&
      (out_item.data.result_hour <= 5'd23)))
    else $error("result date not normalized");

  // a flagged year is saturated
  a_year_saturated: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && out_item.data.year_out_of_range) |->
      ((out_item.data.result_year == 16'd0) ||
       (out_item.data.result_year == dtoa_pkg::YEAR_MAX)))
    else $error("out-of-range year not saturated");

endmodule
